[src/msp_pkg.sv]
`default_nettype none
package msp_pkg;

	// configuration port
	localparam int CFG_W      = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int CFG_IDX_W  = 1;

	// register indexes (paddr[2])
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	localparam logic [CFG_W-1:0] ROWS_RESET = 4'd5;
	localparam logic [CFG_W-1:0] COLS_RESET = 4'd5;

	// fixed widths of the item ports
	localparam int IN_VALUE_W  = 32;
	localparam int OUT_VALUE_W = 32;
	localparam int OUT_IDX_W   = 3;

endpackage
`default_nettype wire

[src/msp_fifo.sv]
`default_nettype none
module msp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[src/msp_front.sv]
`default_nettype none
module msp_front #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32,
	parameter int IW          = $clog2(MAX_DIM),
	parameter int JW          = MAX_DIM * (1 + IW + VALUE_WIDTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [msp_pkg::IN_VALUE_W-1:0] element_value,
	input  wire logic [msp_pkg::CFG_W-1:0]     rows_cfg,
	input  wire logic [msp_pkg::CFG_W-1:0]     cols_cfg,
	output logic                               job_valid,
	input  wire logic                          job_full,
	output logic      [JW-1:0]                 job_data
);

	localparam int NW   = $clog2(MAX_DIM + 1);
	localparam int DW   = (NW > msp_pkg::CFG_W) ? NW : msp_pkg::CFG_W;
	localparam int COFF = MAX_DIM;
	localparam int VOFF = MAX_DIM * (1 + IW);

	// per-row maximum and per-column minimum
	logic [VALUE_WIDTH-1:0] row_max_value_q [MAX_DIM];
	logic [IW-1:0]          row_max_col_q   [MAX_DIM];
	logic [VALUE_WIDTH-1:0] col_min_value_q [MAX_DIM];
	logic [IW-1:0]          col_min_row_q   [MAX_DIM];

	logic [IW-1:0]          cur_row_q;
	logic [IW-1:0]          cur_col_q;
	logic                   pend_q;

	logic [DW-1:0]          rows_c;
	logic [DW-1:0]          cols_c;
	logic [VALUE_WIDTH-1:0] v;
	logic                   acc;
	logic                   col_wrap;
	logic                   row_wrap;
	logic                   upd_row;
	logic                   upd_col;
	logic [MAX_DIM-1:0]     saddle;

	// clamp dimensions to 1..MAX_DIM
	always_comb begin
		if (rows_cfg == '0) begin
			rows_c = DW'(1);
		end else if (DW'(rows_cfg) > DW'(MAX_DIM)) begin
			rows_c = DW'(MAX_DIM);
		end else begin
			rows_c = DW'(rows_cfg);
		end
		if (cols_cfg == '0) begin
			cols_c = DW'(1);
		end else if (DW'(cols_cfg) > DW'(MAX_DIM)) begin
			cols_c = DW'(MAX_DIM);
		end else begin
			cols_c = DW'(cols_cfg);
		end
	end

	// held off while the finished matrix is handed to the queue
	assign full = pend_q;
	assign acc  = push && !pend_q;
	assign v    = VALUE_WIDTH'($unsigned(element_value));

	assign col_wrap = !((DW'(cur_col_q) + DW'(1)) < cols_c);
	assign row_wrap = !((DW'(cur_row_q) + DW'(1)) < rows_c);

	assign upd_row = (cur_col_q == '0) ||
		($signed(v) > $signed(row_max_value_q[cur_row_q]));
	assign upd_col = (cur_row_q == '0) ||
		($signed(v) < $signed(col_min_value_q[cur_col_q]));

	// running row maximum / column minimum
	always_ff @(posedge clk) begin
		if (acc && upd_row) begin
			row_max_value_q[cur_row_q] <= v;
			row_max_col_q[cur_row_q]   <= cur_col_q;
		end
		if (acc && upd_col) begin
			col_min_value_q[cur_col_q] <= v;
			col_min_row_q[cur_col_q]   <= cur_row_q;
		end
	end

	// position and end-of-matrix hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (acc) begin
				if (!col_wrap) begin
					cur_col_q <= cur_col_q + 1'b1;
				end else begin
					cur_col_q <= '0;
					if (!row_wrap) begin
						cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_row_q <= '0;
						pend_q    <= 1'b1;
					end
				end
			end else if (pend_q && !job_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	// row i is a saddle row when its max column has its min in row i
	always_comb begin
		for (int i = 0; i < MAX_DIM; i++) begin
			saddle[i] = 1'b0;
			for (int j = 0; j < MAX_DIM; j++) begin
				if (row_max_col_q[i] == IW'(j) && col_min_row_q[j] == IW'(i)) begin
					saddle[i] = 1'b1;
				end
			end
			if (!(DW'(i) < rows_c)) begin
				saddle[i] = 1'b0;
			end
		end
	end

	// job record: saddle mask, max columns, max values
	always_comb begin
		job_data = '0;
		job_data[MAX_DIM-1:0] = saddle;
		for (int i = 0; i < MAX_DIM; i++) begin
			job_data[COFF + i*IW +: IW]                = row_max_col_q[i];
			job_data[VOFF + i*VALUE_WIDTH +: VALUE_WIDTH] = row_max_value_q[i];
		end
	end

	assign job_valid = pend_q;

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		acc && col_wrap && row_wrap |=> full && cur_row_q == '0 && cur_col_q == '0)
		else $error("last item did not start the hand-off");

	a_job_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !acc)
		else $error("item taken while the matrix is being handed off");

endmodule
`default_nettype wire

[src/msp_back.sv]
`default_nettype none
module msp_back #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32,
	parameter int IW          = $clog2(MAX_DIM),
	parameter int JW          = MAX_DIM * (1 + IW + VALUE_WIDTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            job_empty,
	input  wire logic [JW-1:0]                   job_data,
	output logic                                 job_pop,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 found,
	output logic      [msp_pkg::OUT_IDX_W-1:0]   point_row,
	output logic      [msp_pkg::OUT_IDX_W-1:0]   point_col,
	output logic      [msp_pkg::OUT_VALUE_W-1:0] point_value,
	output logic                                 last_result
);

	localparam int COFF = MAX_DIM;
	localparam int VOFF = MAX_DIM * (1 + IW);

	logic                   act_q;
	logic [MAX_DIM-1:0]     rem_q;
	logic                   ovld_q;
	logic                   found_q;
	logic [IW-1:0]          row_q;
	logic [IW-1:0]          col_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   last_q;

	logic [MAX_DIM-1:0]     head_mask;
	logic [IW-1:0]          head_col [MAX_DIM];
	logic [VALUE_WIDTH-1:0] head_val [MAX_DIM];
	logic [IW-1:0]          pick;
	logic [MAX_DIM-1:0]     rem_next;
	logic                   slot_free;
	logic                   emit;
	logic                   emit_last;

	// unpack the job at the queue head
	always_comb begin
		head_mask = job_data[MAX_DIM-1:0];
		for (int i = 0; i < MAX_DIM; i++) begin
			head_col[i] = job_data[COFF + i*IW +: IW];
			head_val[i] = job_data[VOFF + i*VALUE_WIDTH +: VALUE_WIDTH];
		end
	end

	// lowest remaining saddle row
	always_comb begin
		pick = '0;
		for (int i = MAX_DIM - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick = IW'(i);
			end
		end
	end

	assign rem_next  = rem_q & ~(MAX_DIM'(1) << pick);
	assign slot_free = !ovld_q || pop;
	assign emit      = act_q && slot_free;
	assign emit_last = (rem_q == '0) || (rem_next == '0);
	assign job_pop   = emit && emit_last;

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (!act_q && !job_empty) begin
				act_q <= 1'b1;
			end else if (job_pop) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// remaining mask and output register
	always_ff @(posedge clk) begin
		if (!act_q && !job_empty) begin
			rem_q <= head_mask;
		end else if (emit) begin
			rem_q <= rem_next;
		end
		if (emit) begin
			last_q <= emit_last;
			if (rem_q == '0) begin
				found_q <= 1'b0;
				row_q   <= '0;
				col_q   <= '0;
				val_q   <= '0;
			end else begin
				found_q <= 1'b1;
				row_q   <= pick;
				col_q   <= head_col[pick];
				val_q   <= head_val[pick];
			end
		end
	end

	assign empty       = !ovld_q;
	assign found       = found_q;
	assign point_row   = msp_pkg::OUT_IDX_W'(row_q);
	assign point_col   = msp_pkg::OUT_IDX_W'(col_q);
	assign point_value = msp_pkg::OUT_VALUE_W'(val_q);
	assign last_result = last_q;

	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !found_q |-> last_q)
		else $error("not-found item without the last mark");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> ovld_q && last_q)
		else $error("job retired without a last item");

	a_empty_mask_only: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && rem_q == '0 |-> head_mask == '0 && !job_empty)
		else $error("walk ran dry on a job with saddle rows");

endmodule
`default_nettype wire

[src/matrix_saddle_point_finder.sv]
// Matrix saddle-point finder.
// Input channel (push/full): one matrix element per item, row-major, rows_in_use
// by cols_in_use (each clamped to 1..MAX_DIM). Elements are taken one per cycle
// unless full; after the last element of a matrix full is high for one cycle
// (longer while the job queue holds two unfinished matrices) while the row
// maxima, their columns and the saddle-row mask are handed to a two-entry job
// queue. Result channel (empty/pop): one item per saddle point, rows in
// ascending order, last_result set on the final one; a matrix with no saddle
// point gives a single not-found item with last_result set. The first result
// of a matrix goes from the front's hand-off register through the job queue and
// the walker to the output register, then one per cycle while pop keeps up. A
// stalled receiver holds the output register; the walker waits and the front
// keeps taking elements of the next matrix until the queue is full.
// Configuration (APB, addresses 0: rows_in_use, 4: cols_in_use) is to be written
// by the user only when the block is idle; the block does not enforce it. Reset
// clears the position, the queue and the output; dimensions return to 5 by 5.
`default_nettype none
module matrix_saddle_point_finder #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [msp_pkg::IN_VALUE_W-1:0]    element_value,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   found,
	output logic      [msp_pkg::OUT_IDX_W-1:0]     point_row,
	output logic      [msp_pkg::OUT_IDX_W-1:0]     point_col,
	output logic      [msp_pkg::OUT_VALUE_W-1:0]   point_value,
	output logic                                   last_result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [msp_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [msp_pkg::PDATA_W-1:0]       pwdata,
	output logic      [msp_pkg::PDATA_W-1:0]       prdata,
	output logic                                   pready
);

	localparam int IW = $clog2(MAX_DIM);
	localparam int JW = MAX_DIM * (1 + IW + VALUE_WIDTH);

	logic [msp_pkg::CFG_W-1:0]     rows_q;
	logic [msp_pkg::CFG_W-1:0]     cols_q;
	logic [msp_pkg::CFG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	logic          job_valid;
	logic          job_full;
	logic [JW-1:0] job_wdata;
	logic [JW-1:0] job_rdata;
	logic          job_empty;
	logic          job_pop;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= msp_pkg::ROWS_RESET;
			cols_q <= msp_pkg::COLS_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				msp_pkg::REG_ROWS: rows_q <= pwdata[msp_pkg::CFG_W-1:0];
				msp_pkg::REG_COLS: cols_q <= pwdata[msp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			msp_pkg::REG_ROWS: prdata = msp_pkg::PDATA_W'(rows_q);
			msp_pkg::REG_COLS: prdata = msp_pkg::PDATA_W'(cols_q);
			default:           prdata = '0;
		endcase
	end

	msp_front #(
		.MAX_DIM     (MAX_DIM),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IW          (IW),
		.JW          (JW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.element_value (element_value),
		.rows_cfg      (rows_q),
		.cols_cfg      (cols_q),
		.job_valid     (job_valid),
		.job_full      (job_full),
		.job_data      (job_wdata)
	);

	msp_fifo #(
		.WIDTH (JW),
		.DEPTH (2)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (job_wdata),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_rdata),
		.empty   (job_empty)
	);

	msp_back #(
		.MAX_DIM     (MAX_DIM),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IW          (IW),
		.JW          (JW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (job_empty),
		.job_data    (job_rdata),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.found       (found),
		.point_row   (point_row),
		.point_col   (point_col),
		.point_value (point_value),
		.last_result (last_result)
	);

endmodule
`default_nettype wire

[verif/msp_saddle_checker.sv]
module msp_saddle_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            full,
	input  wire logic [msp_pkg::IN_VALUE_W-1:0]  element_value,
	input  wire logic                            empty,
	input  wire logic                            pop,
	input  wire logic                            found,
	input  wire logic [msp_pkg::OUT_IDX_W-1:0]   point_row,
	input  wire logic [msp_pkg::OUT_IDX_W-1:0]   point_col,
	input  wire logic [msp_pkg::OUT_VALUE_W-1:0] point_value,
	input  wire logic                            last_result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [msp_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [msp_pkg::PDATA_W-1:0]     pwdata,
	input  wire logic                            pready,
	output int                                   open_results,
	output int                                   mismatches
);

	localparam int DIM_LIMIT = 8;

	typedef struct packed {
		logic                            found;
		logic [msp_pkg::OUT_IDX_W-1:0]   row;
		logic [msp_pkg::OUT_IDX_W-1:0]   col;
		logic [msp_pkg::OUT_VALUE_W-1:0] value;
		logic                            last_flag;
	} saddle_t;

	saddle_t saddle_due[$];

	logic [msp_pkg::CFG_W-1:0] rows_cfg;
	logic [msp_pkg::CFG_W-1:0] cols_cfg;

	// per-row maximum and its column, per-column minimum and its row
	logic signed [msp_pkg::IN_VALUE_W-1:0] row_top [DIM_LIMIT];
	int                                    row_top_col [DIM_LIMIT];
	logic signed [msp_pkg::IN_VALUE_W-1:0] col_low [DIM_LIMIT];
	int                                    col_low_row [DIM_LIMIT];
	int                                    pos_row;
	int                                    pos_col;

	function automatic int eff_dim(input logic [msp_pkg::CFG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > DIM_LIMIT)
			return DIM_LIMIT;
		return int'(d);
	endfunction

	// Fold one element into the row/column extremes; on the last element of
	// the matrix, walk the rows and queue the saddle points (or a not-found).
	task automatic take_element(input logic signed [msp_pkg::IN_VALUE_W-1:0] v);
		int      rows;
		int      cols;
		int      r;
		int      c;
		int      i;
		int      mc;
		int      n;
		saddle_t s;
		rows = eff_dim(rows_cfg);
		cols = eff_dim(cols_cfg);
		r = pos_row;
		c = pos_col;
		if (c == 0 || v > row_top[r]) begin
			row_top[r] = v;
			row_top_col[r] = c;
		end
		if (r == 0 || v < col_low[c]) begin
			col_low[c] = v;
			col_low_row[c] = r;
		end
		if (c + 1 < cols) begin
			pos_col = c + 1;
			return;
		end
		pos_col = 0;
		if (r + 1 < rows) begin
			pos_row = r + 1;
			return;
		end
		pos_row = 0;
		n = 0;
		for (i = 0; i < rows; i++) begin
			mc = row_top_col[i];
			if (col_low_row[mc] == i) begin
				s.found = 1'b1;
				s.row = msp_pkg::OUT_IDX_W'(i);
				s.col = msp_pkg::OUT_IDX_W'(mc);
				s.value = row_top[i];
				s.last_flag = 1'b0;
				saddle_due.push_back(s);
				n++;
			end
		end
		if (n == 0) begin
			s = '0;
			s.last_flag = 1'b1;
			saddle_due.push_back(s);
		end else begin
			saddle_due[saddle_due.size()-1].last_flag = 1'b1;
		end
		open_results = saddle_due.size();
	endtask

	task automatic check_result();
		saddle_t e;
		if (saddle_due.size() == 0) begin
			$error("result with nothing expected: row %0d col %0d value %0d",
				point_row, point_col, $signed(point_value));
			mismatches++;
			return;
		end
		e = saddle_due.pop_front();
		open_results = saddle_due.size();
		if (found !== e.found) begin
			$error("found: expected %0b, got %0b", e.found, found);
			mismatches++;
		end
		if (point_row !== e.row) begin
			$error("point_row: expected %0d, got %0d", e.row, point_row);
			mismatches++;
		end
		if (point_col !== e.col) begin
			$error("point_col: expected %0d, got %0d", e.col, point_col);
			mismatches++;
		end
		if (point_value !== e.value) begin
			$error("point_value: expected %0d, got %0d", $signed(e.value),
				$signed(point_value));
			mismatches++;
		end
		if (last_result !== e.last_flag) begin
			$error("last_result: expected %0b, got %0b", e.last_flag, last_result);
			mismatches++;
		end
	endtask

	// sample all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg = msp_pkg::ROWS_RESET;
			cols_cfg = msp_pkg::COLS_RESET;
			pos_row = 0;
			pos_col = 0;
			saddle_due.delete();
			open_results = 0;
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[msp_pkg::PADDR_W-1 -: msp_pkg::CFG_IDX_W] == msp_pkg::REG_ROWS)
					rows_cfg = pwdata[msp_pkg::CFG_W-1:0];
				else if (paddr[msp_pkg::PADDR_W-1 -: msp_pkg::CFG_IDX_W] == msp_pkg::REG_COLS)
					cols_cfg = pwdata[msp_pkg::CFG_W-1:0];
			end
			if (push === 1'b1 && full === 1'b0)
				take_element(element_value);
			if (pop === 1'b1 && empty === 1'b0)
				check_result();
		end
	end

endmodule

[verif/tb_matrix_saddle_point_finder.sv]
module tb_matrix_saddle_point_finder;

	localparam int ITEM_GOAL     = 280;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int CHOKE_CYCLES  = 120;

	// hand-made matrices: 1x1 minimum, 2x2 with no saddle,
	// 3x3 mostly negative with ties, 8x1 column with repeated minimum
	localparam logic [31:0] DIRECTED [22] = '{
		32'h8000_0000,
		1, 2, 2, 1,
		-5, -5, -9, -5, -7, -7, 32'h7fff_ffff, -1, -1,
		3, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, -1, 32'h8000_0000, 1
	};

	typedef enum {FILL_WIDE, FILL_NARROW, FILL_PLANTED, FILL_EXTREME} fill_t;
	typedef enum {PACE_FULL, PACE_COIN, PACE_TRICKLE, PACE_THIRDS} pace_t;

	logic                            clk;
	logic                            arst_n;
	logic                            push;
	logic                            full;
	logic [msp_pkg::IN_VALUE_W-1:0]  element_value;
	logic                            empty;
	logic                            pop;
	logic                            found;
	logic [msp_pkg::OUT_IDX_W-1:0]   point_row;
	logic [msp_pkg::OUT_IDX_W-1:0]   point_col;
	logic [msp_pkg::OUT_VALUE_W-1:0] point_value;
	logic                            last_result;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [msp_pkg::PADDR_W-1:0]     paddr;
	logic [msp_pkg::PDATA_W-1:0]     pwdata;
	logic [msp_pkg::PDATA_W-1:0]     prdata;
	logic                            pready;
	int                              open_results;
	int                              mismatches;

	logic [31:0] cells [64];
	int          burst_left;
	int          sent;
	logic        choke_req;

	matrix_saddle_point_finder dut (.*);

	msp_saddle_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int dim_of(input logic [msp_pkg::CFG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > 8)
			return 8;
		return int'(d);
	endfunction

	// mostly small sizes, with zero, oversize and full size now and then
	function automatic logic [msp_pkg::CFG_W-1:0] pick_dim();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return msp_pkg::CFG_W'($urandom_range(9, 15));
		if (sel <= 3)
			return msp_pkg::CFG_W'(8);
		return msp_pkg::CFG_W'($urandom_range(1, 5));
	endfunction

	task automatic apb_write(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
		input logic [msp_pkg::CFG_W-1:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & 32'hffff_fff0) | d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop offering, wait for every expected result, then let the block go quiet
	task automatic settle();
		int waited;
		push <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (open_results != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dims(input logic [msp_pkg::CFG_W-1:0] r,
		input logic [msp_pkg::CFG_W-1:0] c);
		settle();
		apb_write(msp_pkg::REG_ROWS, r);
		apb_write(msp_pkg::REG_COLS, c);
	endtask

	// send cells[0..n-1] in bursts with random gaps
	task automatic play_cells(input int n);
		int k;
		int gap;
		for (k = 0; k < n; k++) begin
			if (burst_left == 0) begin
				push <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
			end
			push <= 1'b1;
			element_value <= cells[k];
			do @(posedge clk); while (full !== 1'b0);
			burst_left--;
			sent++;
		end
	endtask

	task automatic directed_matrix(input logic [msp_pkg::CFG_W-1:0] r,
		input logic [msp_pkg::CFG_W-1:0] c, input int base);
		int n;
		int k;
		n = dim_of(r) * dim_of(c);
		set_dims(r, c);
		for (k = 0; k < n; k++)
			cells[k] = DIRECTED[base + k];
		play_cells(n);
	endtask

	// random matrix; the planted kind (row offset plus column offset)
	// usually holds a saddle point, narrow values give plenty of ties
	task automatic fill_random(input int rows, input int cols);
		int    i;
		int    j;
		int    f [8];
		int    g [8];
		fill_t mode;
		case ($urandom_range(0, 9))
			0, 1:    mode = FILL_WIDE;
			2, 3, 4: mode = FILL_NARROW;
			5, 6, 7: mode = FILL_PLANTED;
			default: mode = FILL_EXTREME;
		endcase
		for (i = 0; i < 8; i++) begin
			f[i] = int'($urandom_range(0, 2000)) - 1000;
			g[i] = int'($urandom_range(0, 2000)) - 1000;
		end
		for (i = 0; i < rows; i++) begin
			for (j = 0; j < cols; j++) begin
				case (mode)
					FILL_WIDE:   cells[i*cols + j] = $urandom();
					FILL_NARROW: cells[i*cols + j] = $urandom_range(0, 4) - 2;
					FILL_PLANTED: begin
						if ($urandom_range(0, 15) == 0)
							cells[i*cols + j] = $urandom_range(0, 4) - 2;
						else
							cells[i*cols + j] = f[i] + g[j];
					end
					default: begin
						case ($urandom_range(0, 5))
							0:       cells[i*cols + j] = 32'h8000_0000;
							1:       cells[i*cols + j] = 32'h7fff_ffff;
							2:       cells[i*cols + j] = 32'h0;
							3:       cells[i*cols + j] = 32'hffff_ffff;
							4:       cells[i*cols + j] = 32'h1;
							default: cells[i*cols + j] = $urandom();
						endcase
					end
				endcase
			end
		end
	endtask

	// receiver: changing pop patterns, plus one long hold-off on request
	initial begin
		pace_t pace;
		int    span;
		int    tick;
		bit    choke_done;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		pace = PACE_FULL;
		span = 0;
		tick = 0;
		choke_done = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (choke_req === 1'b1 && !choke_done) begin
				choke_done = 1'b1;
				pop <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end else begin
				if (span == 0) begin
					pace = pace_t'($urandom_range(0, 3));
					span = $urandom_range(16, 96);
				end
				span--;
				case (pace)
					PACE_FULL:    pop <= 1'b1;
					PACE_COIN:    pop <= 1'($urandom_range(0, 1));
					PACE_TRICKLE: pop <= ($urandom_range(0, 3) == 0);
					default:      pop <= (tick % 3 != 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin
		int                        rand_base;
		int                        reps;
		int                        rows_n;
		int                        cols_n;
		int                        k;
		logic [msp_pkg::CFG_W-1:0] r_cfg;
		logic [msp_pkg::CFG_W-1:0] c_cfg;
		arst_n <= 1'b0;
		push <= 1'b0;
		element_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		choke_req <= 1'b0;
		burst_left = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed matrices; zero and oversize dimensions included
		directed_matrix(4'd0, 4'd0, 0);
		directed_matrix(4'd2, 4'd2, 1);
		directed_matrix(4'd3, 4'd3, 5);
		directed_matrix(4'd15, 4'd1, 14);

		// small matrices back to back while the receiver holds off
		rand_base = sent;
		set_dims(4'd2, 4'd2);
		choke_req <= 1'b1;
		for (k = 0; k < 8; k++) begin
			fill_random(2, 2);
			play_cells(4);
		end

		// random phases of random sizes
		while (sent - rand_base < ITEM_GOAL) begin
			r_cfg = pick_dim();
			c_cfg = pick_dim();
			rows_n = dim_of(r_cfg);
			cols_n = dim_of(c_cfg);
			set_dims(r_cfg, c_cfg);
			reps = $urandom_range(1, 3);
			for (k = 0; k < reps; k++) begin
				fill_random(rows_n, cols_n);
				play_cells(rows_n * cols_n);
			end
		end

		settle();
		if (open_results != 0)
			$error("%0d expected results never arrived", open_results);
		if (mismatches == 0 && open_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
src/msp_pkg.sv
src/msp_fifo.sv
src/msp_front.sv
src/msp_back.sv
src/matrix_saddle_point_finder.sv
verif/msp_saddle_checker.sv
verif/tb_matrix_saddle_point_finder.sv
